[rtl/core/sdr_pkg.sv]
`default_nettype none
package sdr_pkg;

  // default header length of an executable download
  localparam int unsigned EXE_HEADER_BYTES_DEF = 68;
  localparam logic [6:0]  BIN_HEADER_BYTES     = 7'd12;

  localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT       = 32'hFFFF_FFFF;
  localparam logic [31:0] TAG_EXE        = 32'h4558_454D;
  localparam logic [31:0] TAG_BIN        = 32'h4E49_424D;
  localparam logic [31:0] TAG_PAT        = 32'h5441_504D;
  localparam logic [31:0] PATCH_ADDR_RST = 32'h8001_0000;
  localparam logic [7:0]  TIMEOUT_RST    = 8'd60;
  localparam logic [7:0]  TICK_MAX       = 8'd255;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PATCH_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT = 2'd1;

  typedef enum logic [1:0] {
    KIND_EXE = 2'd0,
    KIND_BIN = 2'd1,
    KIND_PAT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_CMD  = 2'd0,
    PH_HDR  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef enum logic {
    ITEM_BYTE = 1'b0,
    ITEM_TICK = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic        mem_write;
    logic [31:0] mem_address;
    logic [7:0]  mem_data;
    logic        send_ack;
    logic        finished;
    logic [1:0]  load_kind;
    logic        checksum_ok;
    logic        start_execute;
    logic [31:0] entry_address;
    logic        break_on_entry;
  } result_t;

  // replace byte pos of a little-endian word
  function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [1:0] pos,
                                           input logic [7:0] b);
    logic [31:0] w;
    w = word;
    case (pos)
      2'd0:    w[7:0]   = b;
      2'd1:    w[15:8]  = b;
      2'd2:    w[23:16] = b;
      default: w[31:24] = b;
    endcase
    return w;
  endfunction

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[rtl/core/sdr_front.sv]
`default_nettype none
module sdr_front
  import sdr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_push,
  input  wire logic  in_command,
  input  wire logic  [7:0] in_rx_byte,
  output logic       in_full,
  output logic       item_valid,
  output item_t      item,
  input  wire logic  item_pop
);

  // two-entry item queue
  item_t      q_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;
  item_t      in_item;

  assign in_full    = (cnt_r == 2'd2);
  assign item_valid = (cnt_r != 2'd0);
  assign item       = q_r[rd_r];
  assign do_push    = in_push && !in_full;
  assign do_pop     = item_pop && item_valid;

  // classify: tick or received byte
  always_comb begin
    in_item.kind = in_command ? ITEM_TICK : ITEM_BYTE;
    in_item.data = in_rx_byte;
  end

  always_comb begin
    wr_nxt  = do_push ? ~wr_r : wr_r;
    rd_nxt  = do_pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_r] <= in_item;
    end
  end

endmodule
`default_nettype wire

[rtl/core/sdr_engine.sv]
`default_nettype none
module sdr_engine
  import sdr_pkg::*;
#(
  parameter int unsigned EXE_HEADER_BYTES = EXE_HEADER_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  input  wire logic                 item_valid,
  input  wire item_t                item,
  output logic                      item_pop,
  input  wire logic                 res_ready,
  output logic                      res_push,
  output result_t                   res
);

  localparam logic [6:0] EXE_LEN = 7'(EXE_HEADER_BYTES);

  logic [31:0] patch_r;
  logic [7:0]  limit_r;

  phase_t      phase_r, phase_nxt;
  kind_t       kind_r, kind_nxt;
  logic [31:0] cmd_r, cmd_nxt;
  logic [6:0]  idx_r, idx_nxt;
  logic [7:0]  tick_r, tick_nxt;
  logic [31:0] wptr_r, wptr_nxt;
  logic [31:0] left_r, left_nxt;
  logic [31:0] exp_r, exp_nxt;
  logic [31:0] pc_r, pc_nxt;
  logic        brk_r, brk_nxt;
  logic [31:0] crc_r, crc_nxt;

  logic        fire;
  logic        res_valid;
  logic        do_finish;
  logic        ok;
  logic [31:0] crc_fin;
  logic [6:0]  idx_inc;
  logic [6:0]  hdr_len;
  logic [7:0]  b;

  assign fire     = item_valid && res_ready;
  assign item_pop = fire;
  assign res_push = fire && res_valid;
  assign b        = item.data;
  assign idx_inc  = idx_r + 7'd1;
  assign hdr_len  = (kind_r == KIND_EXE) ? EXE_LEN : BIN_HEADER_BYTES;

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    cmd_nxt   = cmd_r;
    idx_nxt   = idx_r;
    tick_nxt  = tick_r;
    wptr_nxt  = wptr_r;
    left_nxt  = left_r;
    exp_nxt   = exp_r;
    pc_nxt    = pc_r;
    brk_nxt   = brk_r;
    crc_nxt   = crc_r;
    res       = '0;
    res_valid = 1'b0;
    do_finish = 1'b0;
    crc_fin   = CRC_INIT;
    ok        = 1'b0;

    if (fire) begin
      case (phase_r)
        PH_HDR: begin
          if (item.kind == ITEM_BYTE) begin
            if (kind_r == KIND_EXE) begin
              if (idx_r inside {[7'd0:7'd3]}) pc_nxt = put_byte(pc_r, idx_r[1:0], b);
              else if (idx_r inside {[7'd8:7'd11]})
                wptr_nxt = put_byte(wptr_r, idx_r[1:0], b);
              else if (idx_r inside {[7'd12:7'd15]})
                left_nxt = put_byte(left_r, idx_r[1:0], b);
              else if (idx_r inside {[7'd60:7'd63]})
                exp_nxt = put_byte(exp_r, idx_r[1:0], b);
              else if (idx_r == 7'd64) brk_nxt = b[0];
            end else begin
              if (idx_r inside {[7'd0:7'd3]}) left_nxt = put_byte(left_r, idx_r[1:0], b);
              else if (idx_r inside {[7'd4:7'd7]})
                wptr_nxt = put_byte(wptr_r, idx_r[1:0], b);
              else if (idx_r inside {[7'd8:7'd11]})
                exp_nxt = put_byte(exp_r, idx_r[1:0], b);
            end
            idx_nxt = idx_inc;
            if (idx_inc >= hdr_len) begin
              if (kind_r == KIND_PAT) begin
                wptr_nxt = patch_r;
                pc_nxt   = patch_r;
              end
              // negative size means no payload
              if (left_nxt[31]) left_nxt = 32'd0;
              crc_nxt   = CRC_INIT;
              idx_nxt   = 7'd0;
              phase_nxt = PH_DATA;
              if (left_nxt == 32'd0) begin
                do_finish = 1'b1;
                crc_fin   = CRC_INIT;
              end
            end
          end
        end
        PH_DATA: begin
          if (item.kind == ITEM_BYTE) begin
            res_valid       = 1'b1;
            res.mem_write   = 1'b1;
            res.mem_address = wptr_r;
            res.mem_data    = b;
            crc_nxt         = crc_byte(crc_r, b);
            wptr_nxt        = wptr_r + 32'd1;
            left_nxt        = left_r - 32'd1;
            if (left_nxt == 32'd0) begin
              do_finish = 1'b1;
              crc_fin   = crc_nxt;
            end
          end
        end
        default: begin
          phase_nxt = PH_CMD;
          if (item.kind == ITEM_TICK) begin
            if (tick_r > limit_r) begin
              cmd_nxt  = 32'd0;
              idx_nxt  = 7'd0;
              tick_nxt = 8'd0;
            end
            if (idx_nxt != 7'd0 && tick_nxt != TICK_MAX) tick_nxt = tick_nxt + 8'd1;
          end else begin
            cmd_nxt = put_byte(cmd_r, idx_r[1:0], b);
            idx_nxt = idx_inc;
            if (idx_inc >= 7'd4) begin
              if (cmd_nxt == TAG_EXE || cmd_nxt == TAG_BIN || cmd_nxt == TAG_PAT) begin
                if (cmd_nxt == TAG_EXE) kind_nxt = KIND_EXE;
                else if (cmd_nxt == TAG_BIN) kind_nxt = KIND_BIN;
                else kind_nxt = KIND_PAT;
                phase_nxt    = PH_HDR;
                idx_nxt      = 7'd0;
                tick_nxt     = 8'd0;
                wptr_nxt     = 32'd0;
                left_nxt     = 32'd0;
                exp_nxt      = 32'd0;
                pc_nxt       = 32'd0;
                brk_nxt      = 1'b0;
                res_valid    = 1'b1;
                res.send_ack = 1'b1;
              end else begin
                cmd_nxt  = 32'd0;
                idx_nxt  = 7'd0;
                tick_nxt = 8'd0;
              end
            end
          end
        end
      endcase

      if (do_finish) begin
        ok                 = ((crc_fin ^ CRC_INIT) == exp_nxt);
        res_valid          = 1'b1;
        res.finished       = 1'b1;
        res.checksum_ok    = ok;
        res.start_execute  = ok && (kind_r != KIND_BIN);
        res.entry_address  = (kind_r == KIND_BIN) ? 32'd0 : pc_nxt;
        res.break_on_entry = (kind_r == KIND_EXE) ? brk_nxt : 1'b0;
        phase_nxt          = PH_CMD;
        cmd_nxt            = 32'd0;
        idx_nxt            = 7'd0;
        tick_nxt           = 8'd0;
      end
    end
    res.load_kind = kind_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      patch_r <= PATCH_ADDR_RST;
      limit_r <= TIMEOUT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_PATCH_ADDRESS) patch_r <= cfg_data;
      else if (cfg_index == REG_TIMEOUT_LIMIT) limit_r <= cfg_data[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CMD;
      kind_r  <= KIND_EXE;
      cmd_r   <= 32'd0;
      idx_r   <= 7'd0;
      tick_r  <= 8'd0;
      wptr_r  <= 32'd0;
      left_r  <= 32'd0;
      exp_r   <= 32'd0;
      pc_r    <= 32'd0;
      brk_r   <= 1'b0;
      crc_r   <= CRC_INIT;
    end else begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      cmd_r   <= cmd_nxt;
      idx_r   <= idx_nxt;
      tick_r  <= tick_nxt;
      wptr_r  <= wptr_nxt;
      left_r  <= left_nxt;
      exp_r   <= exp_nxt;
      pc_r    <= pc_nxt;
      brk_r   <= brk_nxt;
      crc_r   <= crc_nxt;
    end
  end

  // payload phase always has bytes still to come
  a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (left_r != 32'd0))
    else $error("payload phase with no bytes left");

  // command gathering never holds four bytes
  a_cmd_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_CMD) |-> (idx_r < 7'd4))
    else $error("command index out of range");

  // memory writes come only from the payload phase
  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.mem_write) |-> (phase_r == PH_DATA))
    else $error("memory write outside payload phase");

  // a finished download returns to command gathering
  a_finish_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.finished) |=> (phase_r == PH_CMD && idx_r == 7'd0 && cmd_r == 32'd0))
    else $error("no restart after finish");

endmodule
`default_nettype wire

[rtl/core/sdr_out_queue.sv]
`default_nettype none
module sdr_out_queue
  import sdr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    res_push,
  input  wire result_t res,
  output logic         res_ready,
  output logic         out_empty,
  input  wire logic    out_pop,
  output result_t      head
);

  // two-entry result queue
  result_t    q_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign res_ready = (cnt_r != 2'd2);
  assign out_empty = (cnt_r == 2'd0);
  assign head      = q_r[rd_r];
  assign do_push   = res_push && res_ready;
  assign do_pop    = out_pop && !out_empty;

  always_comb begin
    wr_nxt  = do_push ? ~wr_r : wr_r;
    rd_nxt  = do_pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_r] <= res;
    end
  end

endmodule
`default_nettype wire

[rtl/core/serial_download_receiver_top.sv]
// path: an accepted item is held in the front queue, the engine handles it and
//   its result is held in the result queue, whose head drives the out_ ports
// throughput: one item per cycle while the result queue has room, as the engine
//   steps each byte combinationally, including the unrolled byte-wide crc-32 update
// reset: synchronous active-low rst_n empties both queues, returns to command
//   gathering and loads patch_address 0x80010000 and timeout_limit 60
`default_nettype none
module serial_download_receiver_top
  import sdr_pkg::*;
#(
  parameter int unsigned EXE_HEADER_BYTES = EXE_HEADER_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // item input
  input  wire logic                 push,
  output logic                      full,
  input  wire logic                 in_command,
  input  wire logic [7:0]           in_rx_byte,
  // results
  output logic                      empty,
  input  wire logic                 pop,
  output logic                      out_mem_write,
  output logic [31:0]               out_mem_address,
  output logic [7:0]                out_mem_data,
  output logic                      out_send_ack,
  output logic                      out_finished,
  output logic [1:0]                out_load_kind,
  output logic                      out_checksum_ok,
  output logic                      out_start_execute,
  output logic [31:0]               out_entry_address,
  output logic                      out_break_on_entry,
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  item_t   item;
  logic    item_valid;
  logic    item_pop;
  logic    res_ready;
  logic    res_push;
  result_t res;
  result_t head;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  // front: accepts items, tags ticks versus bytes, buffers two
  sdr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (push),
    .in_command (in_command),
    .in_rx_byte (in_rx_byte),
    .in_full    (full),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  // back: command match, header capture, payload writes and crc
  sdr_engine #(
    .EXE_HEADER_BYTES (EXE_HEADER_BYTES)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .res_ready  (res_ready),
    .res_push   (res_push),
    .res        (res)
  );

  // result queue decouples the engine from the consumer
  sdr_out_queue u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res       (res),
    .res_ready (res_ready),
    .out_empty (empty),
    .out_pop   (pop),
    .head      (head)
  );

  assign out_mem_write      = head.mem_write;
  assign out_mem_address    = head.mem_address;
  assign out_mem_data       = head.mem_data;
  assign out_send_ack       = head.send_ack;
  assign out_finished       = head.finished;
  assign out_load_kind      = head.load_kind;
  assign out_checksum_ok    = head.checksum_ok;
  assign out_start_execute  = head.start_execute;
  assign out_entry_address  = head.entry_address;
  assign out_break_on_entry = head.break_on_entry;

endmodule
`default_nettype wire
